### src/fpsb_pkg.sv
// Shared types, constants and helpers for the fan PWM start boost block.
`timescale 1ns / 1ps

package fpsb_pkg;

    localparam int PCT_W      = 7;
    localparam int REQ_W      = 8;
    localparam int TIME_W     = 32;
    localparam int RES_W      = 5;
    localparam int DUTY_W     = 20;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Op codes
    localparam logic OP_SET  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BOOST_PCT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOOST_DUR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RES_BITS  = 2'd2;

    localparam logic [PCT_W-1:0] MAX_PCT      = 7'd100;
    localparam logic [RES_W-1:0] MAX_RES_BITS = 5'd20;
    localparam logic [RES_W-1:0] RES_RESET    = 5'd8;

    // duty = (full * pct + 50) / 100, divide done as multiply by reciprocal
    localparam int PROD_W      = DUTY_W + PCT_W;
    localparam int RECIP_SHIFT = PROD_W + 7;
    localparam int RECIP_W     = 28;
    localparam int QUOT_W      = PROD_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP = 28'd171798692;
    localparam logic [PCT_W-1:0]   ROUND = 7'd50;

    typedef struct packed {
        logic [PCT_W-1:0]  boost_pct;
        logic [TIME_W-1:0] boost_dur;
        logic [RES_W-1:0]  res_bits;
    } cfg_t;

    typedef struct packed {
        logic             valid;
        logic [PCT_W-1:0] cmd;
        logic [PCT_W-1:0] app;
        logic             boost;
        logic             wrote;
    } lvl_t;

    function automatic logic [PCT_W-1:0] clamp_pct(input logic [REQ_W-1:0] p);
        logic [PCT_W-1:0] r;
        if (p > REQ_W'(MAX_PCT))
            r = MAX_PCT;
        else
            r = p[PCT_W-1:0];
        return r;
    endfunction

endpackage

### src/fan_pwm_start_boost_top.sv
// Fan PWM start boost top level: config registers, control and duty pipeline.
// A result passes the request register, level stage, product stage and result register.
// Throughput: one request per cycle while out_stall is low.
// While a result waits, up to three more requests are taken before in_stall rises.
// Reset: levels, boost and deadline cleared; boost_percent 0, duration 0,
// resolution 8 bits; no duty is written on reset.
`timescale 1ns / 1ps

module fan_pwm_start_boost_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [fpsb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fpsb_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             op,
    input  logic [fpsb_pkg::REQ_W-1:0]       percent,
    input  logic [fpsb_pkg::TIME_W-1:0]      now_ms,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [fpsb_pkg::PCT_W-1:0]       commanded_percent,
    output logic [fpsb_pkg::PCT_W-1:0]       applied_percent,
    output logic                             boost_active,
    output logic                             duty_write,
    output logic [fpsb_pkg::DUTY_W-1:0]      duty
);
    import fpsb_pkg::*;

    cfg_t cfg_reg;
    lvl_t lvl;
    logic dn_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.boost_pct <= '0;
            cfg_reg.boost_dur <= '0;
            cfg_reg.res_bits  <= RES_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_BOOST_PCT)
                cfg_reg.boost_pct <= cfg_data[PCT_W-1:0];
            if (cfg_index == CFG_BOOST_DUR)
                cfg_reg.boost_dur <= cfg_data[TIME_W-1:0];
            if (cfg_index == CFG_RES_BITS)
                cfg_reg.res_bits <= cfg_data[RES_W-1:0];
        end
    end

    fpsb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .op       (op),
        .percent  (percent),
        .now_ms   (now_ms),
        .cfg      (cfg_reg),
        .dn_ready (dn_ready),
        .lvl      (lvl)
    );

    fpsb_duty u_duty (
        .clk               (clk),
        .rst_n             (rst_n),
        .lvl               (lvl),
        .dn_ready          (dn_ready),
        .res_bits          (cfg_reg.res_bits),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .commanded_percent (commanded_percent),
        .applied_percent   (applied_percent),
        .boost_active      (boost_active),
        .duty_write        (duty_write),
        .duty              (duty)
    );

endmodule

### src/fpsb_ctrl.sv
// Request register and command/boost state update.
`timescale 1ns / 1ps

module fpsb_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         op,
    input  logic [fpsb_pkg::REQ_W-1:0]   percent,
    input  logic [fpsb_pkg::TIME_W-1:0]  now_ms,
    input  fpsb_pkg::cfg_t               cfg,
    input  logic                         dn_ready,
    output fpsb_pkg::lvl_t               lvl
);
    import fpsb_pkg::*;

    logic              s0_valid_reg;
    logic              op_reg;
    logic [PCT_W-1:0]  pct_reg;
    logic [TIME_W-1:0] now_reg;

    logic [PCT_W-1:0]  cmd_reg, cmd_next;
    logic [PCT_W-1:0]  app_reg, app_next;
    logic              boost_reg, boost_next;
    logic [TIME_W-1:0] dl_reg, dl_next;
    logic              wrote_next;

    lvl_t              lvl_reg;

    logic              s0_take;
    logic              s0_move;
    logic              s1_free;
    logic              stopped;
    logic [TIME_W-1:0] diff;

    assign s1_free  = !lvl_reg.valid || dn_ready;
    assign s0_move  = s0_valid_reg && s1_free;
    assign in_stall = s0_valid_reg && !s1_free;
    assign s0_take  = in_valid && !in_stall;
    assign stopped  = (cmd_reg == '0) && (app_reg == '0);
    assign diff     = now_reg - dl_reg;
    assign lvl      = lvl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (s0_take)
        begin
            s0_valid_reg <= 1'b1;
        end
        else if (s0_move)
        begin
            s0_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s0_take)
        begin
            op_reg  <= op;
            pct_reg <= clamp_pct(percent);
            now_reg <= now_ms;
        end
    end

    always_comb
    begin
        cmd_next   = cmd_reg;
        app_next   = app_reg;
        boost_next = boost_reg;
        dl_next    = dl_reg;
        wrote_next = 1'b0;
        if (s0_move)
        begin
            unique case (op_reg)
                OP_SET:
                begin
                    if (pct_reg != cmd_reg)
                    begin
                        cmd_next   = pct_reg;
                        wrote_next = 1'b1;
                        priority if (pct_reg == '0)
                        begin
                            boost_next = 1'b0;
                            dl_next    = '0;
                            app_next   = '0;
                        end
                        else if (stopped && (pct_reg < cfg.boost_pct))
                        begin
                            boost_next = 1'b1;
                            dl_next    = now_reg + cfg.boost_dur;
                            app_next   = clamp_pct({1'b0, cfg.boost_pct});
                        end
                        else
                        begin
                            boost_next = 1'b0;
                            dl_next    = '0;
                            app_next   = pct_reg;
                        end
                    end
                end
                OP_TICK:
                begin
                    if (boost_reg && !diff[TIME_W-1])
                    begin
                        boost_next = 1'b0;
                        dl_next    = '0;
                        app_next   = cmd_reg;
                        wrote_next = 1'b1;
                    end
                end
                default:
                begin
                    cmd_next = cmd_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg   <= '0;
            app_reg   <= '0;
            boost_reg <= 1'b0;
            dl_reg    <= '0;
        end
        else
        begin
            cmd_reg   <= cmd_next;
            app_reg   <= app_next;
            boost_reg <= boost_next;
            dl_reg    <= dl_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lvl_reg <= '0;
        end
        else if (s1_free)
        begin
            lvl_reg.valid <= s0_valid_reg;
            lvl_reg.cmd   <= cmd_next;
            lvl_reg.app   <= app_next;
            lvl_reg.boost <= boost_next;
            lvl_reg.wrote <= wrote_next;
        end
    end

    // boost only runs from a non-zero command at a non-zero level
    a_boost_levels: assert property (@(posedge clk) disable iff (!rst_n)
        boost_reg |-> (cmd_reg != '0) && (app_reg != '0))
        else $error("boost active with zero level");

    a_deadline_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !boost_reg |-> (dl_reg == '0))
        else $error("deadline set without boost");

    a_lvl_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (lvl_reg.valid && !dn_ready) |=> (lvl_reg.valid && $stable(lvl_reg)))
        else $error("level stage lost while downstream full");

    a_state_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !s0_move |=> ($stable(cmd_reg) && $stable(app_reg) && $stable(boost_reg)))
        else $error("state changed without a request");

endmodule

### src/fpsb_duty.sv
// Duty scaling pipeline and result register.
`timescale 1ns / 1ps

module fpsb_duty (
    input  logic                         clk,
    input  logic                         rst_n,
    input  fpsb_pkg::lvl_t               lvl,
    output logic                         dn_ready,
    input  logic [fpsb_pkg::RES_W-1:0]   res_bits,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [fpsb_pkg::PCT_W-1:0]   commanded_percent,
    output logic [fpsb_pkg::PCT_W-1:0]   applied_percent,
    output logic                         boost_active,
    output logic                         duty_write,
    output logic [fpsb_pkg::DUTY_W-1:0]  duty
);
    import fpsb_pkg::*;

    lvl_t              s2_reg;
    logic [PROD_W-1:0] prod_reg;
    logic              out_valid_reg;
    logic [PCT_W-1:0]  cmd_out_reg;
    logic [PCT_W-1:0]  app_out_reg;
    logic              boost_out_reg;
    logic              wrote_out_reg;
    logic [DUTY_W-1:0] duty_reg;

    logic              out_free;
    logic              s2_free;
    logic [RES_W-1:0]  bits_sat;
    logic [DUTY_W:0]   full_ext;
    logic [DUTY_W-1:0] full;
    logic [PROD_W-1:0] prod_next;
    logic [QUOT_W-1:0] quot;

    assign out_free = !out_valid_reg || !out_stall;
    assign s2_free  = !s2_reg.valid || out_free;
    assign dn_ready = s2_free;

    assign bits_sat  = (res_bits > MAX_RES_BITS) ? MAX_RES_BITS : res_bits;
    assign full_ext  = ((DUTY_W + 1)'(1) << bits_sat) - (DUTY_W + 1)'(1);
    assign full      = full_ext[DUTY_W-1:0];
    assign prod_next = PROD_W'(full) * PROD_W'(lvl.app) + PROD_W'(ROUND);
    assign quot      = QUOT_W'(prod_reg) * QUOT_W'(RECIP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s2_free)
            begin
                s2_reg <= lvl;
            end
            if (out_free)
            begin
                out_valid_reg <= s2_reg.valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_free)
        begin
            prod_reg <= prod_next;
        end
        if (out_free)
        begin
            cmd_out_reg   <= s2_reg.cmd;
            app_out_reg   <= s2_reg.app;
            boost_out_reg <= s2_reg.boost;
            wrote_out_reg <= s2_reg.wrote;
            duty_reg      <= quot[RECIP_SHIFT+DUTY_W-1:RECIP_SHIFT];
        end
    end

    assign out_valid         = out_valid_reg;
    assign commanded_percent = cmd_out_reg;
    assign applied_percent   = app_out_reg;
    assign boost_active      = boost_out_reg;
    assign duty_write        = wrote_out_reg;
    assign duty              = duty_reg;

endmodule

### sim/fan_pwm_start_boost_top_tb.sv
// Testbench for fan_pwm_start_boost_top: directed table, then random phases.
`timescale 1ns / 1ps

module fan_pwm_start_boost_top_tb;

    import fpsb_pkg::*;

    typedef struct packed {
        logic [PCT_W-1:0]  cmd;
        logic [PCT_W-1:0]  app;
        logic              boost;
        logic              wrote;
        logic [DUTY_W-1:0] duty;
    } fan_out_t;

    typedef struct {
        logic                  is_cfg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic                  op;
        logic [REQ_W-1:0]      pct;
        logic [TIME_W-1:0]     now;
        logic                  chk;
        fan_out_t              exp;
    } script_row_t;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam logic ROW_ITEM = 1'b0;
    localparam logic ROW_CFG  = 1'b1;
    localparam fan_out_t NONE = '0;
    localparam fan_out_t FULL_STOP = {7'd0, 7'd0, 1'b0, 1'b1, 20'd0};

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic                  op;
    logic [REQ_W-1:0]      percent;
    logic [TIME_W-1:0]     now_ms;
    logic                  out_valid;
    logic                  out_stall;
    logic [PCT_W-1:0]      commanded_percent;
    logic [PCT_W-1:0]      applied_percent;
    logic                  boost_active;
    logic                  duty_write;
    logic [DUTY_W-1:0]     duty;

    // predictor copy of registers and state
    logic [PCT_W-1:0]  cfg_boost_pct;
    logic [TIME_W-1:0] cfg_boost_dur;
    logic [RES_W-1:0]  cfg_res;
    logic [PCT_W-1:0]  cmd_lvl;
    logic [PCT_W-1:0]  app_lvl;
    logic              boosting;
    logic [TIME_W-1:0] deadline;

    fan_out_t pending_outs[$];
    script_row_t script[$];

    int  n_bad;
    int  n_requests;
    int  n_results;
    int  n_cfg;
    int  n_boost_starts;
    int  n_boost_ends;
    bit  tx_quiet;
    bit  rx_quiet;

    fan_pwm_start_boost_top DUT (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .op                (op),
        .percent           (percent),
        .now_ms            (now_ms),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .commanded_percent (commanded_percent),
        .applied_percent   (applied_percent),
        .boost_active      (boost_active),
        .duty_write        (duty_write),
        .duty              (duty)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("timeout: %0d results still outstanding", pending_outs.size());
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [DUTY_W-1:0] duty_count(input logic [PCT_W-1:0] lvl);
        logic [RES_W-1:0] bits;
        logic [63:0]      full;
        logic [63:0]      d;
        bits = (cfg_res > MAX_RES_BITS) ? MAX_RES_BITS : cfg_res;
        full = (64'd1 << bits) - 64'd1;
        d = (full * 64'(lvl) + 64'd50) / 64'd100;
        return d[DUTY_W-1:0];
    endfunction

    task automatic fan_step(input logic op_i, input logic [REQ_W-1:0] req,
                            input logic [TIME_W-1:0] now_i, output fan_out_t r);
        logic [PCT_W-1:0]  p;
        logic              stopped;
        logic              wrote;
        logic [TIME_W-1:0] diff;
        wrote = 1'b0;
        if (op_i == OP_SET)
        begin
            p = (req > REQ_W'(MAX_PCT)) ? MAX_PCT : req[PCT_W-1:0];
            if (p != cmd_lvl)
            begin
                stopped = (cmd_lvl == '0) && (app_lvl == '0);
                cmd_lvl = p;
                wrote = 1'b1;
                if (p == '0)
                begin
                    boosting = 1'b0;
                    deadline = '0;
                    app_lvl = '0;
                end
                else if (stopped && p < cfg_boost_pct)
                begin
                    boosting = 1'b1;
                    deadline = now_i + cfg_boost_dur;
                    app_lvl = (cfg_boost_pct > MAX_PCT) ? MAX_PCT : cfg_boost_pct;
                    n_boost_starts++;
                end
                else
                begin
                    boosting = 1'b0;
                    deadline = '0;
                    app_lvl = p;
                end
            end
        end
        else if (boosting)
        begin
            diff = now_i - deadline;
            if (!diff[TIME_W-1])
            begin
                boosting = 1'b0;
                deadline = '0;
                app_lvl = cmd_lvl;
                wrote = 1'b1;
                n_boost_ends++;
            end
        end
        r.cmd   = cmd_lvl;
        r.app   = app_lvl;
        r.boost = boosting;
        r.wrote = wrote;
        r.duty  = duty_count(app_lvl);
    endtask

    // called at a falling edge; waits until every result is back
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        in_valid = 1'b0;
        while (pending_outs.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_BOOST_PCT: cfg_boost_pct = data[PCT_W-1:0];
            CFG_BOOST_DUR: cfg_boost_dur = data[TIME_W-1:0];
            CFG_RES_BITS:  cfg_res = data[RES_W-1:0];
            default: ;
        endcase
        n_cfg++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_req(input logic op_i, input logic [REQ_W-1:0] pct_i,
                            input logic [TIME_W-1:0] now_i, input logic chk,
                            input fan_out_t exp);
        fan_out_t r;
        int       gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 7);
        if (gap != 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        op = op_i;
        percent = pct_i;
        now_ms = now_i;
        do @(posedge clk); while (in_stall);
        fan_step(op_i, pct_i, now_i, r);
        pending_outs.push_back(chk ? exp : r);
        n_requests++;
        @(negedge clk);
    endtask

    // result side: random stall before each result, check on acceptance
    initial
    begin
        fan_out_t got;
        fan_out_t want;
        int       hold;
        out_stall = 1'b0;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                got.cmd   = commanded_percent;
                got.app   = applied_percent;
                got.boost = boost_active;
                got.wrote = duty_write;
                got.duty  = duty;
                n_results++;
                if (pending_outs.size() == 0)
                begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display({"%0t: result with none expected: ",
                                  "cmd=%0d app=%0d boost=%0b wr=%0b duty=%0d"},
                                 $realtime, got.cmd, got.app, got.boost, got.wrote,
                                 got.duty);
                end
                else
                begin
                    want = pending_outs.pop_front();
                    if (got.cmd !== want.cmd || got.app !== want.app ||
                        got.boost !== want.boost || got.wrote !== want.wrote ||
                        got.duty !== want.duty)
                    begin
                        n_bad++;
                        if (n_bad <= 10)
                            $display({"%0t: mismatch exp cmd=%0d app=%0d boost=%0b ",
                                      "wr=%0b duty=%0d | got cmd=%0d app=%0d ",
                                      "boost=%0b wr=%0b duty=%0d"},
                                     $realtime, want.cmd, want.app, want.boost,
                                     want.wrote, want.duty, got.cmd, got.app,
                                     got.boost, got.wrote, got.duty);
                    end
                end
                hold = rx_quiet ? 0 : $urandom_range(0, 7);
            end
            @(negedge clk);
            if (hold > 0)
            begin
                out_stall = 1'b1;
                hold--;
            end
            else
                out_stall = 1'b0;
        end
    end

    initial
    begin
        logic [CFG_DATA_W-1:0] data;
        logic [TIME_W-1:0]     t_ms;
        logic [TIME_W-1:0]     now_v;
        logic [TIME_W-1:0]     step_max;
        logic [REQ_W-1:0]      pct_v;
        logic                  op_v;
        int                    pick;

        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        op = OP_SET;
        percent = '0;
        now_ms = '0;
        n_bad = 0;
        n_requests = 0;
        n_results = 0;
        n_cfg = 0;
        n_boost_starts = 0;
        n_boost_ends = 0;
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        cfg_boost_pct = '0;
        cfg_boost_dur = '0;
        cfg_res = RES_RESET;
        cmd_lvl = '0;
        app_lvl = '0;
        boosting = 1'b0;
        deadline = '0;

        // reset registers: boost 0, duration 0, 8 bits
        script.push_back('{ROW_ITEM, CFG_SPARE, 32'd0, OP_TICK, 8'hFF, 32'd0, 1'b1, NONE});
        script.push_back('{ROW_ITEM, CFG_SPARE, 32'd0, OP_SET, 8'd255, 32'd0, 1'b1,
                           {7'd100, 7'd100, 1'b0, 1'b1, 20'd255}});
        script.push_back('{ROW_ITEM, CFG_SPARE, 32'd0, OP_SET, 8'd101, 32'd1, 1'b1,
                           {7'd100, 7'd100, 1'b0, 1'b0, 20'd255}});
        script.push_back('{ROW_ITEM, CFG_SPARE, 32'd0, OP_SET, 8'd0, 32'd2, 1'b1, FULL_STOP});
        script.push_back('{ROW_ITEM, CFG_SPARE, 32'd0, OP_SET, 8'd1, 32'd3, 1'b1,
                           {7'd1, 7'd1, 1'b0, 1'b1, 20'd3}});
        script.push_back('{ROW_ITEM, CFG_SPARE, 32'd0, OP_SET, 8'd0, 32'd4, 1'b1, FULL_STOP});
        // boost above 100, deadline wraps past zero, 20-bit resolution
        script.push_back('{ROW_CFG, CFG_BOOST_PCT, 32'hFFFF_FFFF, OP_SET, 8'd0, 32'd0, 1'b0,
                           NONE});
        script.push_back('{ROW_CFG, CFG_BOOST_DUR, 32'h10, OP_SET, 8'd0, 32'd0, 1'b0, NONE});
        script.push_back('{ROW_CFG, CFG_RES_BITS, 32'h14, OP_SET, 8'd0, 32'd0, 1'b0, NONE});
        script.push_back('{ROW_CFG, CFG_SPARE, 32'hDEAD_BEEF, OP_SET, 8'd0, 32'd0, 1'b0, NONE});
        script.push_back('{ROW_ITEM, CFG_SPARE, 32'd0, OP_SET, 8'd30, 32'hFFFF_FFF8, 1'b1,
                           {7'd30, 7'd100, 1'b1, 1'b1, 20'hFFFFF}});
        script.push_back('{ROW_ITEM, CFG_SPARE, 32'd0, OP_TICK, 8'd77, 32'd7, 1'b1,
                           {7'd30, 7'd100, 1'b1, 1'b0, 20'hFFFFF}});
        script.push_back('{ROW_ITEM, CFG_SPARE, 32'd0, OP_TICK, 8'd0, 32'd8, 1'b1,
                           {7'd30, 7'd30, 1'b0, 1'b1, 20'd314573}});
        script.push_back('{ROW_ITEM, CFG_SPARE, 32'd0, OP_SET, 8'd80, 32'd9, 1'b0, NONE});
        script.push_back('{ROW_ITEM, CFG_SPARE, 32'd0, OP_TICK, 8'd0, 32'd10, 1'b0, NONE});
        script.push_back('{ROW_ITEM, CFG_SPARE, 32'd0, OP_SET, 8'd0, 32'd11, 1'b1, FULL_STOP});
        // zero resolution, boost of exactly 100, longest duration
        script.push_back('{ROW_CFG, CFG_RES_BITS, 32'd0, OP_SET, 8'd0, 32'd0, 1'b0, NONE});
        script.push_back('{ROW_CFG, CFG_BOOST_PCT, 32'd100, OP_SET, 8'd0, 32'd0, 1'b0, NONE});
        script.push_back('{ROW_CFG, CFG_BOOST_DUR, 32'hFFFF_FFFF, OP_SET, 8'd0, 32'd0, 1'b0,
                           NONE});
        script.push_back('{ROW_ITEM, CFG_SPARE, 32'd0, OP_SET, 8'd99, 32'd5, 1'b1,
                           {7'd99, 7'd100, 1'b1, 1'b1, 20'd0}});
        script.push_back('{ROW_ITEM, CFG_SPARE, 32'd0, OP_TICK, 8'd0, 32'h8000_0004, 1'b1,
                           {7'd99, 7'd100, 1'b1, 1'b0, 20'd0}});
        script.push_back('{ROW_ITEM, CFG_SPARE, 32'd0, OP_TICK, 8'd0, 32'h8000_0003, 1'b1,
                           {7'd99, 7'd99, 1'b0, 1'b1, 20'd0}});
        script.push_back('{ROW_ITEM, CFG_SPARE, 32'd0, OP_SET, 8'd0, 32'd6, 1'b1, FULL_STOP});
        script.push_back('{ROW_ITEM, CFG_SPARE, 32'd0, OP_SET, 8'd100, 32'd0, 1'b1,
                           {7'd100, 7'd100, 1'b0, 1'b1, 20'd0}});
        script.push_back('{ROW_ITEM, CFG_SPARE, 32'd0, OP_SET, 8'd0, 32'd0, 1'b1, FULL_STOP});
        // resolution above 20 saturates, boost 101, zero duration
        script.push_back('{ROW_CFG, CFG_RES_BITS, 32'd31, OP_SET, 8'd0, 32'd0, 1'b0, NONE});
        script.push_back('{ROW_CFG, CFG_BOOST_PCT, 32'd101, OP_SET, 8'd0, 32'd0, 1'b0, NONE});
        script.push_back('{ROW_CFG, CFG_BOOST_DUR, 32'd0, OP_SET, 8'd0, 32'd0, 1'b0, NONE});
        script.push_back('{ROW_ITEM, CFG_SPARE, 32'd0, OP_SET, 8'd1, 32'd123, 1'b1,
                           {7'd1, 7'd100, 1'b1, 1'b1, 20'hFFFFF}});
        script.push_back('{ROW_ITEM, CFG_SPARE, 32'd0, OP_SET, 8'd5, 32'd124, 1'b0, NONE});
        script.push_back('{ROW_ITEM, CFG_SPARE, 32'd0, OP_SET, 8'd0, 32'd125, 1'b1, FULL_STOP});
        script.push_back('{ROW_ITEM, CFG_SPARE, 32'd0, OP_SET, 8'd10, 32'd500, 1'b1,
                           {7'd10, 7'd100, 1'b1, 1'b1, 20'hFFFFF}});
        script.push_back('{ROW_ITEM, CFG_SPARE, 32'd0, OP_TICK, 8'd200, 32'd500, 1'b0, NONE});
        script.push_back('{ROW_ITEM, CFG_SPARE, 32'd0, OP_SET, 8'd0, 32'd501, 1'b1, FULL_STOP});
        script.push_back('{ROW_ITEM, CFG_SPARE, 32'd0, OP_TICK, 8'd0, 32'hFFFF_FFFF, 1'b0,
                           NONE});

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (script[i])
        begin
            if (script[i].is_cfg == ROW_CFG)
                write_reg(script[i].idx, script[i].data);
            else
                send_req(script[i].op, script[i].pct, script[i].now, script[i].chk,
                         script[i].exp);
        end

        for (int ph = 0; ph < 8; ph++)
        begin
            data = $urandom;
            case (ph)
                0: data[PCT_W-1:0] = 7'd0;
                1: data[PCT_W-1:0] = 7'd127;
                2: data[PCT_W-1:0] = MAX_PCT;
                default: data[PCT_W-1:0] = PCT_W'($urandom_range(20, 100));
            endcase
            write_reg(CFG_BOOST_PCT, data);
            case (ph % 4)
                0: data = 32'd0;
                1: data = 32'hFFFF_FFFF;
                2: data = $urandom_range(1, 40);
                default: data = (ph == 7) ? $urandom : $urandom_range(100, 5000);
            endcase
            write_reg(CFG_BOOST_DUR, data);
            step_max = (data == 0) ? 4 : (data[31] ? 1000 : data / 6 + 1);
            data = $urandom;
            case (ph)
                0: data[RES_W-1:0] = 5'd20;
                1: data[RES_W-1:0] = 5'd1;
                2: data[RES_W-1:0] = 5'd31;
                default: data[RES_W-1:0] = RES_W'($urandom_range(0, 31));
            endcase
            write_reg(CFG_RES_BITS, data);
            write_reg(CFG_SPARE, $urandom);

            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            t_ms = ph[0] ? 32'hFFFF_FFFF - $urandom_range(0, 3000) : $urandom;

            for (int k = 0; k < 100; k++)
            begin
                op_v = ($urandom_range(0, 99) < 45) ? OP_TICK : OP_SET;
                pick = $urandom_range(0, 99);
                if (pick < 20)
                    pct_v = 8'd0;
                else if (pick < 30)
                    pct_v = REQ_W'($urandom_range(101, 255));
                else if (pick < 40)
                    pct_v = {1'b0, cmd_lvl};
                else
                    pct_v = REQ_W'($urandom_range(1, 100));
                if (op_v == OP_TICK && $urandom_range(0, 1) == 0)
                    pct_v = REQ_W'($urandom);
                now_v = ($urandom_range(0, 19) == 0) ? $urandom : t_ms;
                t_ms = t_ms + $urandom_range(0, step_max);
                send_req(op_v, pct_v, now_v, 1'b0, NONE);
            end
        end

        in_valid = 1'b0;
        while (pending_outs.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("run: %0d requests, %0d results, %0d register writes, 8 random settings",
                 n_requests, n_results, n_cfg);
        $display("boosts started %0d, ended by tick %0d, mismatches %0d",
                 n_boost_starts, n_boost_ends, n_bad);
        if (n_bad == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
